[rtl/ugbc_pkg.sv]
`timescale 1ns / 1ps

package ugbc_pkg;

   typedef enum logic [1:0] {
      VERDICT_INVALID   = 2'd0,
      VERDICT_MULTIBYTE = 2'd1,
      VERDICT_PLAIN     = 2'd2
   } verdict_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } word_type;

   localparam logic [7:0] BYTE_ASCII_END  = 8'h80;
   localparam logic [7:0] BYTE_LEAD2_LO   = 8'hC0;
   localparam logic [7:0] BYTE_OVERLONG   = 8'hC1;
   localparam logic [7:0] BYTE_LEAD3_LO   = 8'hE0;
   localparam logic [7:0] BYTE_LEAD4_LO   = 8'hF0;
   localparam logic [7:0] BYTE_LEAD5_LO   = 8'hF8;
   localparam logic [7:0] BYTE_LEAD6_LO   = 8'hFC;
   localparam logic [7:0] BYTE_LEAD6_HI   = 8'hFD;
   localparam logic [7:0] GBK_LEAD_LO     = 8'h81;
   localparam logic [7:0] GBK_HI          = 8'hFE;
   localparam logic [7:0] GBK_TRAIL_LO    = 8'h40;
   localparam logic [1:0] CONT_TAG        = 2'b10;

endpackage

[rtl/ugbc_scan.sv]
`timescale 1ns / 1ps

module ugbc_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  ugbc_pkg::word_type   word,
   output ugbc_pkg::verdict_type verdict
);

   logic [2:0] utf_left_ff, utf_left_in;
   logic       only_ascii_ff, only_ascii_in;
   logic       long_lead_ff, long_lead_in;
   logic       utf_broken_ff, utf_broken_in;
   logic       gbk_due_ff, gbk_due_in;
   logic       gbk_broken_ff, gbk_broken_in;
   logic       overlong_ff, overlong_in;
   logic [7:0] b;

   assign b = word.data;

   always_comb begin
      utf_left_in   = utf_left_ff;
      only_ascii_in = only_ascii_ff;
      long_lead_in  = long_lead_ff;
      utf_broken_in = utf_broken_ff;
      overlong_in   = overlong_ff;
      if (utf_left_ff == 3'd0) begin
         if (b[7]) only_ascii_in = 1'b0;
         priority if (b < ugbc_pkg::BYTE_ASCII_END) begin
            utf_left_in = 3'd0;
         end else if (b >= ugbc_pkg::BYTE_LEAD6_LO && b <= ugbc_pkg::BYTE_LEAD6_HI) begin
            utf_left_in  = 3'd5;
            long_lead_in = 1'b1;
         end else if (b >= ugbc_pkg::BYTE_LEAD5_LO) begin
            utf_left_in  = 3'd4;
            long_lead_in = 1'b1;
         end else if (b >= ugbc_pkg::BYTE_LEAD4_LO) begin
            utf_left_in  = 3'd3;
            long_lead_in = 1'b1;
         end else if (b >= ugbc_pkg::BYTE_LEAD3_LO) begin
            utf_left_in  = 3'd2;
            long_lead_in = 1'b1;
         end else if (b >= ugbc_pkg::BYTE_LEAD2_LO) begin
            utf_left_in = 3'd1;
            if (b <= ugbc_pkg::BYTE_OVERLONG) overlong_in = 1'b1;
         end else begin
            utf_broken_in = 1'b1;
         end
      end else begin
         if (b[7:6] != ugbc_pkg::CONT_TAG) utf_broken_in = 1'b1;
         utf_left_in = utf_left_ff - 3'd1;
      end
   end

   always_comb begin
      gbk_due_in    = gbk_due_ff;
      gbk_broken_in = gbk_broken_ff;
      if (!gbk_due_ff) begin
         if (b[7]) begin
            if (b >= ugbc_pkg::GBK_LEAD_LO && b <= ugbc_pkg::GBK_HI) gbk_due_in = 1'b1;
            else gbk_broken_in = 1'b1;
         end
      end else begin
         if (b < ugbc_pkg::GBK_TRAIL_LO || b > ugbc_pkg::GBK_HI) gbk_broken_in = 1'b1;
         gbk_due_in = 1'b0;
      end
   end

   always_comb begin
      priority if (utf_broken_in || utf_left_in != 3'd0) begin
         verdict = ugbc_pkg::VERDICT_INVALID;
      end else if (only_ascii_in) begin
         verdict = ugbc_pkg::VERDICT_PLAIN;
      end else if (long_lead_in || gbk_broken_in || gbk_due_in) begin
         verdict = ugbc_pkg::VERDICT_MULTIBYTE;
      end else if (overlong_in) begin
         verdict = ugbc_pkg::VERDICT_INVALID;
      end else begin
         verdict = ugbc_pkg::VERDICT_MULTIBYTE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (word.valid && word.last)) begin
         utf_left_ff   <= 3'd0;
         only_ascii_ff <= 1'b1;
         long_lead_ff  <= 1'b0;
         utf_broken_ff <= 1'b0;
         gbk_due_ff    <= 1'b0;
         gbk_broken_ff <= 1'b0;
         overlong_ff   <= 1'b0;
      end else if (word.valid) begin
         utf_left_ff   <= utf_left_in;
         only_ascii_ff <= only_ascii_in;
         long_lead_ff  <= long_lead_in;
         utf_broken_ff <= utf_broken_in;
         gbk_due_ff    <= gbk_due_in;
         gbk_broken_ff <= gbk_broken_in;
         overlong_ff   <= overlong_in;
      end
   end

endmodule

[rtl/utf8_gbk_byte_stream_classifier_top.sv]
`timescale 1ns / 1ps

// Classifies a string sent one byte per word, the final byte marked by
// req_last_byte, and returns one verdict word per string (0 invalid, 1 multibyte
// UTF-8 text, 2 all ASCII). A byte is taken in every cycle that req_stall is
// low; it passes an input register and the UTF-8 and GBK state update, and its
// verdict is registered into the two-entry result buffer, which drives rsp_valid.
// req_stall rises only when the result buffer, counting a verdict still in
// flight, holds two words and none leaves in that cycle.
module utf8_gbk_byte_stream_classifier_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_verdict
);

   ugbc_pkg::word_type    word_ff, word_in;
   ugbc_pkg::verdict_type verdict;
   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_verdict_ff, out_verdict_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [1:0]            skid_verdict_ff, skid_verdict_in;
   logic                  push, pop, out_free;
   logic [1:0]            occupancy;

   assign occupancy = {1'b0, out_valid_ff} + {1'b0, skid_valid_ff}
                    + {1'b0, word_ff.valid & word_ff.last};
   assign req_stall = (occupancy >= 2'd2) && !pop;

   always_comb begin
      word_in.valid = req_valid && !req_stall;
      word_in.data  = req_data_byte;
      word_in.last  = req_last_byte;
   end

   ugbc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .word    (word_ff),
      .verdict (verdict)
   );

   assign push     = word_ff.valid && word_ff.last;
   assign pop      = out_valid_ff && !rsp_stall;
   assign out_free = !out_valid_ff || pop;

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_verdict_in  = out_verdict_ff;
      skid_valid_in   = skid_valid_ff;
      skid_verdict_in = skid_verdict_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in    = 1'b1;
            out_verdict_in  = skid_verdict_ff;
            skid_valid_in   = push;
            skid_verdict_in = verdict;
         end else begin
            out_valid_in   = push;
            out_verdict_in = verdict;
         end
      end else if (push) begin
         skid_valid_in   = 1'b1;
         skid_verdict_in = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         word_ff.valid <= word_in.valid;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      word_ff.data    <= word_in.data;
      word_ff.last    <= word_in.last;
      out_verdict_ff  <= out_verdict_in;
      skid_verdict_ff <= skid_verdict_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_verdict = out_verdict_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !out_free |-> !skid_valid_ff)
      else $error("verdict pushed into full result buffer");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict != 2'd3)
      else $error("undefined verdict code on output");

endmodule
